[hw/rtl/bb3_pkg.sv]
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 box blur: pixel layout, raster
// counter widths, register indexes and the records passed between stages.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WEFF_W     = COL_W + 1;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int IN_ROW_W   = HEIGHT_W;
  localparam int OUT_ROW_W  = HEIGHT_W - 1;
  localparam int CFG_DATA_W = HEIGHT_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic top;
    logic bottom;
    logic left;
    logic right;
  } blur_ctrl_t;

  typedef struct packed {
    pixel_t            px;
    logic [COL_W-1:0]  col;
    blur_ctrl_t        ctrl;
  } bb3_item_t;

  typedef struct packed {
    logic              last;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  blue;
    logic [SUM_W-1:0]  green;
    logic [SUM_W-1:0]  red;
  } bb3_acc_t;

endpackage

[hw/rtl/bb3_ram.sv]
// ----------------------------------------------------------------------------
// bb3_ram
// Generic simple dual-port RAM with one write port and one registered read
// port. A read at the address being written returns the old data.
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bb3_ctrl.sv]
// ----------------------------------------------------------------------------
// bb3_ctrl
// Configuration registers and raster counters. Decides per beat whether the
// item enters the pipeline, which line buffer column it uses, whether it
// produces an output pixel and which neighbors of that pixel are inside.
// ----------------------------------------------------------------------------
module bb3_ctrl
  import bb3_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  pixel_t                pixel_i,
  input  logic                  is_pad_i,
  output logic                  take_o,
  output bb3_item_t             item_o
);

  logic [WIDTH_W-1:0]   width_q, width_d;
  logic [HEIGHT_W-1:0]  height_q, height_d;
  logic [COL_W-1:0]     in_col_q, in_col_d;
  logic [IN_ROW_W-1:0]  in_row_q, in_row_d;
  logic [COL_W-1:0]     out_col_q, out_col_d;
  logic [OUT_ROW_W-1:0] out_row_q, out_row_d;

  logic [WEFF_W-1:0]    w_eff;
  logic [HEIGHT_W-1:0]  h_eff;
  logic                 flushing;
  logic [WEFF_W-1:0]    in_col_next;
  logic                 in_wrap;
  logic [WEFF_W-1:0]    out_col_next;
  logic [HEIGHT_W-1:0]  out_row_next;
  blur_ctrl_t           ctrl;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(width_q);
    end
    h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
  end

  assign flushing     = in_row_q >= h_eff;
  assign in_col_next  = {1'b0, in_col_q} + WEFF_W'(1);
  assign in_wrap      = in_col_next >= w_eff;
  assign out_col_next = {1'b0, out_col_q} + WEFF_W'(1);
  assign out_row_next = {1'b0, out_row_q} + HEIGHT_W'(1);

  always_comb begin
    ctrl.emit   = (in_row_q > IN_ROW_W'(1)) ||
                  ((in_row_q == IN_ROW_W'(1)) && (in_col_q != '0));
    ctrl.top    = out_row_q != '0;
    ctrl.bottom = out_row_next < h_eff;
    ctrl.left   = out_col_q != '0;
    ctrl.right  = out_col_next < w_eff;
    ctrl.last   = !ctrl.bottom && !ctrl.right;
  end

  assign take_o      = accept_i && (flushing || !is_pad_i);
  assign item_o.px   = flushing ? '0 : pixel_i;
  assign item_o.col  = in_col_q;
  assign item_o.ctrl = ctrl;

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_d  = cfg_data_i[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_d = cfg_data_i[HEIGHT_W-1:0];
      endcase
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (take_o) begin
      in_col_d = in_wrap ? '0 : in_col_next[COL_W-1:0];
      in_row_d = in_wrap ? IN_ROW_W'(in_row_q + 1'b1) : in_row_q;
      if (ctrl.emit) begin
        if (ctrl.last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (ctrl.right) begin
          out_col_d = out_col_next[COL_W-1:0];
        end else begin
          out_col_d = '0;
          out_row_d = out_row_next[OUT_ROW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_W'(1);
      height_q  <= HEIGHT_W'(1);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  a_in_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, in_col_q} < w_eff)
    else $error("input column ran past the row width");

  a_out_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, out_col_q} < w_eff)
    else $error("output column ran past the row width");

  a_out_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, out_row_q} < h_eff)
    else $error("output row ran past the frame height");

endmodule

[hw/rtl/bb3_linebuf.sv]
// ----------------------------------------------------------------------------
// bb3_linebuf
// Two line buffers holding the previous two rows. Each item reads its column
// when it is accepted and writes the new column back one stage later; a
// write and read of the same column in one cycle is forwarded.
// ----------------------------------------------------------------------------
module bb3_linebuf
  import bb3_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       take_i,
  input  bb3_item_t  item_i,
  output logic       valid_o,
  output pixel_t     above2_o,
  output pixel_t     above_o,
  output pixel_t     px_o,
  output blur_ctrl_t ctrl_o
);

  logic      s1_valid_q;
  bb3_item_t s1_item_q;
  logic      fwd_q;
  pixel_t    fwd_a_q;
  pixel_t    fwd_b_q;
  pixel_t    ram_a_rdata;
  pixel_t    ram_b_rdata;
  pixel_t    above_eff;
  pixel_t    above2_eff;
  logic      wr_en;

  assign above_eff  = fwd_q ? fwd_a_q : ram_a_rdata;
  assign above2_eff = fwd_q ? fwd_b_q : ram_b_rdata;
  assign wr_en      = en_i && s1_valid_q;

  bb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_item_q.col),
    .wdata_i (s1_item_q.px),
    .re_i    (take_i),
    .raddr_i (item_i.col),
    .rdata_o (ram_a_rdata)
  );

  bb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_item_q.col),
    .wdata_i (above_eff),
    .re_i    (take_i),
    .raddr_i (item_i.col),
    .rdata_o (ram_b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= take_i;
      fwd_q      <= take_i && s1_valid_q && (item_i.col == s1_item_q.col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_item_q <= item_i;
    end
    if (en_i) begin
      fwd_a_q <= s1_item_q.px;
      fwd_b_q <= above_eff;
    end
  end

  assign valid_o  = s1_valid_q;
  assign above2_o = above2_eff;
  assign above_o  = above_eff;
  assign px_o     = s1_item_q.px;
  assign ctrl_o   = s1_item_q.ctrl;

  a_fwd_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("forwarded column without an item in the read stage");

endmodule

[hw/rtl/bb3_window.sv]
// ----------------------------------------------------------------------------
// bb3_window
// The 3x3 window that slides along the stream, followed by a stage that
// adds up the neighbors inside the image per channel and counts them.
// ----------------------------------------------------------------------------
module bb3_window
  import bb3_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  pixel_t     above2_i,
  input  pixel_t     above_i,
  input  pixel_t     px_i,
  input  blur_ctrl_t ctrl_i,
  output logic       acc_valid_o,
  output bb3_acc_t   acc_o
);

  pixel_t     win_q [3][3];
  logic       s2_valid_q;
  blur_ctrl_t s2_ctrl_q;
  logic       acc_valid_q;
  bb3_acc_t   acc_q;
  bb3_acc_t   acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (en_i && valid_i) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= above2_i;
      win_q[1][2] <= above_i;
      win_q[2][2] <= px_i;
    end
  end

  always_comb begin
    logic [2:0]       row_en;
    logic [2:0]       col_en;
    logic [1:0]       rows;
    logic [1:0]       cols;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    row_en = {s2_ctrl_q.bottom, 1'b1, s2_ctrl_q.top};
    col_en = {s2_ctrl_q.right, 1'b1, s2_ctrl_q.left};
    rows   = 2'd1 + 2'(s2_ctrl_q.top) + 2'(s2_ctrl_q.bottom);
    cols   = 2'd1 + 2'(s2_ctrl_q.left) + 2'(s2_ctrl_q.right);
    sum_r  = '0;
    sum_g  = '0;
    sum_b  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_en[r] && col_en[c]) begin
          sum_r = sum_r + SUM_W'(win_q[r][c].red);
          sum_g = sum_g + SUM_W'(win_q[r][c].green);
          sum_b = sum_b + SUM_W'(win_q[r][c].blue);
        end
      end
    end
    acc_d.count = CNT_W'(rows) * CNT_W'(cols);
    acc_d.red   = sum_r + SUM_W'(acc_d.count >> 1);
    acc_d.green = sum_g + SUM_W'(acc_d.count >> 1);
    acc_d.blue  = sum_b + SUM_W'(acc_d.count >> 1);
    acc_d.last  = s2_ctrl_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      acc_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q  <= valid_i && ctrl_i.emit;
      acc_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      s2_ctrl_q <= ctrl_i;
    end
    if (en_i && s2_valid_q) begin
      acc_q <= acc_d;
    end
  end

  assign acc_valid_o = acc_valid_q;
  assign acc_o       = acc_q;

endmodule

[hw/rtl/bb3_out.sv]
// ----------------------------------------------------------------------------
// bb3_out
// Rounded division of the channel sums by the neighbor count, and the
// output register with a skid register behind it.
// ----------------------------------------------------------------------------
module bb3_out
  import bb3_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     acc_valid_i,
  input  bb3_acc_t acc_i,
  output logic     ready_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  output pixel_t   m_px_o,
  output logic     m_last_o
);

  localparam int THIRD_MUL   = 2731;
  localparam int THIRD_SHIFT = 13;
  localparam int NINTH_MUL   = 7282;
  localparam int NINTH_SHIFT = 16;
  localparam int PROD_W      = SUM_W + 13;

  typedef struct packed {
    logic   last;
    pixel_t px;
  } result_t;

  // Rounding is already folded into the sum, so a floor division remains.
  // Divisions by 3 and 9 use a reciprocal that is exact for 12-bit sums.
  function automatic logic [CHAN_W-1:0] chan_mean(logic [SUM_W-1:0] m,
                                                  logic [CNT_W-1:0] cnt);
    logic [SUM_W-1:0]  num;
    logic [PROD_W-1:0] mul;
    logic [PROD_W-1:0] prod;
    num  = (cnt == CNT_W'(6)) ? (m >> 1) : m;
    mul  = (cnt == CNT_W'(9)) ? PROD_W'(NINTH_MUL) : PROD_W'(THIRD_MUL);
    prod = PROD_W'(num) * mul;
    case (cnt)
      CNT_W'(2): chan_mean = CHAN_W'(m >> 1);
      CNT_W'(4): chan_mean = CHAN_W'(m >> 2);
      CNT_W'(3), CNT_W'(6): chan_mean = CHAN_W'(prod >> THIRD_SHIFT);
      CNT_W'(9): chan_mean = CHAN_W'(prod >> NINTH_SHIFT);
      default:   chan_mean = CHAN_W'(m);
    endcase
  endfunction

  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t res;
  logic    push;

  assign ready_o = !skid_valid_q;
  assign push    = acc_valid_i && !skid_valid_q;

  always_comb begin
    res.last     = acc_i.last;
    res.px.red   = chan_mean(acc_i.red, acc_i.count);
    res.px.green = chan_mean(acc_i.green, acc_i.count);
    res.px.blue  = chan_mean(acc_i.blue, acc_i.count);
  end

  always_comb begin
    main_d       = main_q;
    skid_d       = skid_q;
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    if (main_valid_q && !m_ready_i) begin
      if (push) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (skid_valid_q) begin
      main_d       = skid_q;
      main_valid_d = 1'b1;
      skid_valid_d = 1'b0;
    end else begin
      main_d       = res;
      main_valid_d = push;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign m_valid_o = main_valid_q;
  assign m_px_o    = main_q.px;
  assign m_last_o  = main_q.last;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid register holds a beat while the output register is empty");

endmodule

[hw/rtl/box_blur_3x3.sv]
// ----------------------------------------------------------------------------
// box_blur_3x3
// Streaming 3x3 box blur of an RGB image with edge-aware rounded means.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the s_axis channel, one beat per pixel,
// with tuser set on flush beats. After the width*height pixels of a frame
// the source sends width+1 flush beats, which push out the last row. Each
// output beat on m_axis carries the blurred pixel; tlast marks the last
// pixel of the frame. Size registers are written through the cfg port while
// the block is idle, a duty of the user that the block does not enforce;
// any write restarts the frame. Throughput is one beat per cycle while
// s_axis_tready_o is high, set by the single read and write port of each
// line buffer. A result leaves the output register after the beat that
// completes its neighborhood, a row and a pixel after the pixel itself.
// Reset clears the counters and the pipeline and sets the size to 1x1; the
// line buffers are not cleared, since edge masking never uses stale data.
// When the receiver stalls, a skid register takes one more result and then
// s_axis_tready_o drops until the output drains.
// ----------------------------------------------------------------------------
module box_blur_3x3
  import bb3_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [PIX_W-1:0]      s_axis_tdata_i,   // red_in, green_in, blue_in
  input  logic                  s_axis_tuser_i,   // is_pad
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [PIX_W-1:0]      m_axis_tdata_o,   // red_out, green_out, blue_out
  output logic                  m_axis_tlast_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic       en;
  logic       accept;
  logic       take;
  bb3_item_t  item;
  logic       col_valid;
  pixel_t     above2;
  pixel_t     above;
  pixel_t     px;
  blur_ctrl_t ctrl;
  logic       acc_valid;
  bb3_acc_t   acc;
  pixel_t     m_px;

  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;

  bb3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .pixel_i     (pixel_t'(s_axis_tdata_i)),
    .is_pad_i    (s_axis_tuser_i),
    .take_o      (take),
    .item_o      (item)
  );

  bb3_linebuf u_linebuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .take_i   (take),
    .item_i   (item),
    .valid_o  (col_valid),
    .above2_o (above2),
    .above_o  (above),
    .px_o     (px),
    .ctrl_o   (ctrl)
  );

  bb3_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (col_valid),
    .above2_i    (above2),
    .above_i     (above),
    .px_i        (px),
    .ctrl_i      (ctrl),
    .acc_valid_o (acc_valid),
    .acc_o       (acc)
  );

  bb3_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_valid_i (acc_valid),
    .acc_i       (acc),
    .ready_o     (en),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_px_o      (m_px),
    .m_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = m_px;

endmodule
